>>> rtl/pbmws_pkg.sv
`timescale 1ns / 1ps

package pbmws_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DELTA_W  = SAMPLE_W + 1;
  localparam int unsigned SUM_W    = 19;
  localparam int unsigned CFG_W    = 10;

  // Result queue behind the pipeline. It must cover every request in flight.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } result_t;

endpackage

>>> rtl/per_bin_moving_window_sum.sv
`timescale 1ns / 1ps

// Per-element moving sum over the last WINDOW_FRAMES spectral frames.
// Input requests (in_valid_i/in_ready_o) carry one signed Q1.15 element each;
// a frame is (frame_size/2+1)*2 interleaved real and imaginary elements.
// Each request yields exactly one result (out_valid_o/out_ready_i) with the
// updated sum for that element position and a flag on the last element.
// Throughput is one request per cycle while in_ready_o is high. The memory
// read happens at the edge that takes the request; the result then passes
// the history difference, the sum update and the result queue before
// out_valid_o rises and the result can be taken.
// The result queue holds 8 entries. When the receiver stalls, requests keep
// being taken until 8 of them are outstanding, then in_ready_o drops;
// nothing is lost or repeated.
// After reset the history and sum memories are zeroed one entry per cycle,
// covering WINDOW_FRAMES*(MAX_FRAME_SIZE+2) history entries (4112 at the defaults), with
// in_ready_o low. The frame_size register resets to 512 and may be written
// (cfg_we_i/cfg_wdata_i) at any time while the block is idle; a write
// restarts the element position at the start of a frame.
module per_bin_moving_window_sum #(
  parameter int unsigned WINDOW_FRAMES  = 8,
  parameter int unsigned MAX_FRAME_SIZE = 512
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pbmws_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pbmws_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pbmws_pkg::SUM_W-1:0]    smoothed_sum_o,
  output logic                                  frame_last_o
);

  localparam int unsigned MAX_ELEMS  = MAX_FRAME_SIZE + 2;
  localparam int unsigned HIST_DEPTH = WINDOW_FRAMES * MAX_ELEMS;
  localparam int unsigned PW         = $clog2(MAX_ELEMS);
  localparam int unsigned AW         = $clog2(HIST_DEPTH);
  localparam int unsigned LAST_BASE  = (WINDOW_FRAMES - 1) * MAX_ELEMS;
  localparam int unsigned FS_RST     = 512;
  localparam int unsigned LAST_RST   =
      ((FS_RST > MAX_FRAME_SIZE) ? MAX_FRAME_SIZE : FS_RST) | 1;
  localparam int unsigned CNT_W      = pbmws_pkg::FIFO_CNT_W;

  logic             clearing_q, clearing_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [PW-1:0]    last_pos_q, last_pos_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    base_q, base_d;
  logic [CNT_W-1:0] credit_q, credit_d;
  logic [AW-1:0]    haddr;
  logic             is_last;
  logic             in_acc;
  logic             out_acc;
  logic             pipe_valid;

  pbmws_pkg::result_t pipe_result;
  pbmws_pkg::result_t out_result;

  assign in_ready_o = !clearing_q && (credit_q < CNT_W'(pbmws_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign is_last    = (pos_q == last_pos_q);
  assign haddr      = base_q + AW'(pos_q);

  // The last position of a frame is the clamped frame size with bit 0 set.
  always_comb begin
    if (int'(cfg_wdata_i) > MAX_FRAME_SIZE) begin
      last_pos_d = PW'(MAX_FRAME_SIZE | 1);
    end else begin
      last_pos_d = PW'(cfg_wdata_i) | PW'(1);
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(HIST_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // base_q addresses the history slot of the oldest frame.
  always_comb begin
    pos_d  = pos_q;
    base_d = base_q;
    if (cfg_we_i) begin
      pos_d = '0;
    end else if (in_acc) begin
      if (is_last) begin
        pos_d = '0;
        if (base_q == AW'(LAST_BASE)) begin
          base_d = '0;
        end else begin
          base_d = base_q + AW'(MAX_ELEMS);
        end
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end
    credit_d = credit_q + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      last_pos_q <= PW'(LAST_RST);
      pos_q      <= '0;
      base_q     <= '0;
      credit_q   <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      if (cfg_we_i) begin
        last_pos_q <= last_pos_d;
      end
      pos_q      <= pos_d;
      base_q     <= base_d;
      credit_q   <= credit_d;
    end
  end

  pbmws_pipe #(
    .MAX_ELEMS  (MAX_ELEMS),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_acc),
    .sample_i   (sample_i),
    .pos_i      (pos_q),
    .haddr_i    (haddr),
    .last_i     (is_last),
    .clr_en_i   (clearing_q),
    .clr_addr_i (clr_cnt_q),
    .valid_o    (pipe_valid),
    .result_o   (pipe_result)
  );

  pbmws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pipe_valid),
    .data_i  (pipe_result),
    .pop_i   (out_acc),
    .valid_o (out_valid_o),
    .data_o  (out_result)
  );

  assign smoothed_sum_o = out_result.sum;
  assign frame_last_o   = out_result.last;

endmodule

>>> rtl/pbmws_ram.sv
`timescale 1ns / 1ps

module pbmws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/pbmws_pipe.sv
`timescale 1ns / 1ps

module pbmws_pipe #(
  parameter int unsigned MAX_ELEMS = 514,
  parameter int unsigned HIST_DEPTH = 4112
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic signed [pbmws_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [$clog2(MAX_ELEMS)-1:0]            pos_i,
  input  logic [$clog2(HIST_DEPTH)-1:0]           haddr_i,
  input  logic                                    last_i,
  input  logic                                    clr_en_i,
  input  logic [$clog2(HIST_DEPTH)-1:0]           clr_addr_i,
  output logic                                    valid_o,
  output pbmws_pkg::result_t                      result_o
);

  localparam int unsigned PW = $clog2(MAX_ELEMS);
  localparam int unsigned AW = $clog2(HIST_DEPTH);
  localparam int unsigned SW = pbmws_pkg::SUM_W;
  localparam int unsigned DW = pbmws_pkg::DELTA_W;
  localparam int unsigned XW = pbmws_pkg::SAMPLE_W;

  // Stage 1: memory read data is aligned with these registers.
  logic                 v1_q;
  logic signed [XW-1:0] samp1_q;
  logic [PW-1:0]        pos1_q;
  logic [AW-1:0]        haddr1_q;
  logic                 last1_q;
  // Stage 2: difference and forwarded old sum.
  logic                 v2_q;
  logic [PW-1:0]        pos2_q;
  logic                 last2_q;
  logic signed [SW-1:0] sum2_q;
  logic signed [DW-1:0] delta2_q;
  // Stage 3: finished sum.
  logic                 v3_q;
  logic [PW-1:0]        pos3_q;
  logic                 last3_q;
  logic signed [SW-1:0] sum3_q;

  logic [XW-1:0]        hist_rd;
  logic [SW-1:0]        sum_rd;
  logic                 hist_we;
  logic [AW-1:0]        hist_waddr;
  logic [XW-1:0]        hist_wdata;
  logic                 sum_we;
  logic [PW-1:0]        sum_waddr;
  logic [SW-1:0]        sum_wdata;
  logic signed [SW-1:0] sum_fwd;
  logic signed [DW-1:0] delta_d;
  logic signed [SW-1:0] sum_new;

  // The history entry is rewritten in the cycle after its read, long before the
  // same entry comes around again, so it needs no bypass.
  always_comb begin
    if (clr_en_i) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr_i;
      hist_wdata = '0;
    end else begin
      hist_we    = v1_q;
      hist_waddr = haddr1_q;
      hist_wdata = samp1_q;
    end
  end

  always_comb begin
    if (clr_en_i) begin
      sum_we    = (int'(clr_addr_i) < MAX_ELEMS);
      sum_waddr = clr_addr_i[PW-1:0];
      sum_wdata = '0;
    end else begin
      sum_we    = v2_q;
      sum_waddr = pos2_q;
      sum_wdata = sum_new;
    end
  end

  pbmws_ram #(
    .WIDTH (XW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (haddr_i),
    .rdata_o (hist_rd)
  );

  pbmws_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ELEMS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (pos_i),
    .rdata_o (sum_rd)
  );

  // With two elements per frame, a sum written in stage 2 is read back by the
  // request two behind it in the same cycle, so the memory still shows the
  // old value. That sum is then sitting in stage 3.
  always_comb begin
    if (v3_q && (pos3_q == pos1_q)) begin
      sum_fwd = sum3_q;
    end else begin
      sum_fwd = sum_rd;
    end
    delta_d = {samp1_q[XW-1], samp1_q} - {hist_rd[XW-1], hist_rd};
  end

  assign sum_new = sum2_q + {{(SW-DW){delta2_q[DW-1]}}, delta2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    samp1_q  <= sample_i;
    pos1_q   <= pos_i;
    haddr1_q <= haddr_i;
    last1_q  <= last_i;
    pos2_q   <= pos1_q;
    last2_q  <= last1_q;
    sum2_q   <= sum_fwd;
    delta2_q <= delta_d;
    pos3_q   <= pos2_q;
    last3_q  <= last2_q;
    sum3_q   <= sum_new;
  end

  assign valid_o       = v3_q;
  assign result_o.sum  = sum3_q;
  assign result_o.last = last3_q;

endmodule

>>> rtl/pbmws_fifo.sv
`timescale 1ns / 1ps

module pbmws_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pbmws_pkg::result_t data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output pbmws_pkg::result_t data_o
);

  localparam int unsigned PTR_W = pbmws_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = pbmws_pkg::FIFO_CNT_W;

  pbmws_pkg::result_t mem_q [pbmws_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // The producer never pushes into a full queue: the top level holds back
  // requests until there is room for their results.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule
